FILE: hw/rtl/vqbpd_pkg.sv
// ----------------------------------------------------------------------------
// vqbpd_pkg
// Shared constants for the vector-pointer decoder: command kinds, parser
// stages, register indexes and default configuration values.
// ----------------------------------------------------------------------------
package vqbpd_pkg;

    // default line pitch in pixels
    localparam int LINE_PITCH_DEF = 640;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int BCNT_W  = 16;
    localparam int SRC_W   = 13;
    localparam int LEN_W   = 8;
    localparam int EXTRA_W = 7;
    localparam int FOFS_W  = 29;
    localparam int CBOFS_W = 20;
    localparam int BPL_W   = 8;
    localparam int BDIM_W  = 4;

    // command kinds, top 3 bits of the command word
    localparam logic [2:0] K_SKIP   = 3'd0;
    localparam logic [2:0] K_RUN    = 3'd1;
    localparam logic [2:0] K_LIST   = 3'd2;
    localparam logic [2:0] K_ONE    = 3'd3;
    localparam logic [2:0] K_ONE_T  = 3'd4;
    localparam logic [2:0] K_CNT    = 3'd5;
    localparam logic [2:0] K_CNT_T  = 3'd6;

    // parser stages
    localparam logic [1:0] PS_LOW   = 2'd0;
    localparam logic [1:0] PS_HIGH  = 2'd1;
    localparam logic [1:0] PS_COUNT = 2'd2;
    localparam logic [1:0] PS_EXTRA = 2'd3;

    // result kinds
    localparam logic RK_PLACE = 1'b0;
    localparam logic RK_UNDEF = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_BPL = 2'd0;
    localparam logic [1:0] REG_BW  = 2'd1;
    localparam logic [1:0] REG_BH  = 2'd2;

    // configuration reset values
    localparam logic [BPL_W-1:0]  BPL_RST = 8'd160;
    localparam logic [BDIM_W-1:0] BW_RST  = 4'd4;
    localparam logic [BDIM_W-1:0] BH_RST  = 4'd2;

endpackage

FILE: hw/rtl/vq_block_pointer_decoder_core.sv
// ----------------------------------------------------------------------------
// vq_block_pointer_decoder_core
// Parses the vector-pointer byte stream and emits one run descriptor per
// block placement or undefined command, with pixel and codebook offsets.
// ----------------------------------------------------------------------------
// sequence: a placing byte steps through the 16-step restoring divider that
//   splits the block index into row and column, then two multiply states and
//   the finish state; the input stalls until the result is loaded. A byte with
//   no result is taken while idle; an undefined command goes to finish directly
// reset: asynchronous, clears parser, block counter and output valid, and
//   loads the configuration registers with their defaults
module vq_block_pointer_decoder_core
    import vqbpd_pkg::*;
#(
    parameter int LINE_PITCH = LINE_PITCH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  stream_byte,
    input  logic               frame_end,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [BCNT_W-1:0]  first_block,
    output logic [SRC_W-1:0]   source_block,
    output logic [LEN_W-1:0]   run_length,
    output logic               transparent,
    output logic [FOFS_W-1:0]  frame_offset,
    output logic [CBOFS_W-1:0] codebook_offset
);

    localparam int STRIDE_W = $clog2(LINE_PITCH + 1);
    localparam logic [STRIDE_W-1:0] STRIDE_C = STRIDE_W'(LINE_PITCH);
    localparam int COL_W  = BPL_W + BDIM_W;
    localparam int ROW_W  = BCNT_W + BDIM_W;
    localparam int AREA_W = 2 * BDIM_W;
    localparam int PROD_W = ROW_W + STRIDE_W;
    localparam int CB_W   = SRC_W + AREA_W;
    localparam int SUM_W  = (PROD_W > FOFS_W) ? PROD_W + 1 : FOFS_W + 1;
    localparam int CNT_W  = $clog2(BCNT_W);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_MUL1   = 3'd2;
    localparam logic [2:0] ST_MUL2   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]         state_reg, state_next;

    // configuration registers
    logic [BPL_W-1:0]   bpl_reg;
    logic [BDIM_W-1:0]  bw_reg;
    logic [BDIM_W-1:0]  bh_reg;

    // parser state
    logic [1:0]         stage_reg, stage_next;
    logic [BYTE_W-1:0]  low_reg, low_next;
    logic [SRC_W-1:0]   psrc_reg, psrc_next;
    logic               ptr_reg, ptr_next;
    logic [EXTRA_W-1:0] extra_reg, extra_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;

    // working registers of the current transaction
    logic               err_reg;
    logic [BCNT_W-1:0]  dst_reg;
    logic [SRC_W-1:0]   src_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               tr_reg;
    logic [BCNT_W-1:0]  quo_reg;
    logic [BPL_W-1:0]   rem_reg;
    logic [BPL_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [PROD_W-1:0]  rowpix_reg;
    logic [CB_W-1:0]    cb_reg;

    // output register
    logic               out_valid_reg;
    logic               kind_reg;
    logic [BCNT_W-1:0]  first_reg;
    logic [SRC_W-1:0]   osrc_reg;
    logic [LEN_W-1:0]   olen_reg;
    logic               otr_reg;
    logic [FOFS_W-1:0]  fofs_reg;
    logic [CBOFS_W-1:0] cbofs_reg;

    logic               in_acc;
    logic               out_acc;
    logic               cfg_wr;
    logic               out_load;

    logic [15:0]        cmd;
    logic [2:0]         ckind;
    logic [5:0]         half;
    logic [EXTRA_W-1:0] pairs;
    logic [EXTRA_W-1:0] extra_dec;
    logic               start_run;
    logic               start_err;
    logic [SRC_W-1:0]   run_src;
    logic [LEN_W-1:0]   run_len;
    logic               run_tr;

    logic [BYTE_W:0]    div_shift;
    logic [BYTE_W+1:0]  div_diff;
    logic               div_borrow;
    logic [SUM_W-1:0]   fsum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg <= BPL_RST;
            bw_reg  <= BW_RST;
            bh_reg  <= BH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BPL: bpl_reg <= pwdata[BPL_W-1:0];
                REG_BW:  bw_reg  <= pwdata[BDIM_W-1:0];
                REG_BH:  bh_reg  <= pwdata[BDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration read
    always_comb
    begin
        case (paddr[3:2])
            REG_BPL: prdata = {24'd0, bpl_reg};
            REG_BW:  prdata = {28'd0, bw_reg};
            REG_BH:  prdata = {28'd0, bh_reg};
            default: prdata = 32'd0;
        endcase
    end

    // command decode
    assign cmd       = {stream_byte, low_reg};
    assign ckind     = cmd[15:13];
    assign half      = {1'b0, cmd[12:8]} + 6'd1;
    assign pairs     = {half, 1'b0};
    assign extra_dec = (extra_reg == '0) ? '0 : extra_reg - 7'd1;

    // parser and block counter
    always_comb
    begin
        stage_next = stage_reg;
        low_next   = low_reg;
        psrc_next  = psrc_reg;
        ptr_next   = ptr_reg;
        extra_next = extra_reg;
        bcnt_next  = bcnt_reg;
        start_run  = 1'b0;
        start_err  = 1'b0;
        run_src    = '0;
        run_len    = '0;
        run_tr     = 1'b0;
        if (in_acc)
        begin
            case (stage_reg)
                PS_LOW:
                begin
                    low_next   = stream_byte;
                    stage_next = PS_HIGH;
                end
                PS_HIGH:
                begin
                    stage_next = PS_LOW;
                    case (ckind)
                        K_SKIP:
                        begin
                            bcnt_next = bcnt_reg + {3'd0, cmd[12:0]};
                        end
                        K_RUN:
                        begin
                            start_run = 1'b1;
                            run_src   = {5'd0, cmd[7:0]};
                            run_len   = {1'b0, pairs};
                        end
                        K_LIST:
                        begin
                            start_run  = 1'b1;
                            run_src    = {5'd0, cmd[7:0]};
                            run_len    = 8'd1;
                            extra_next = pairs;
                            stage_next = PS_EXTRA;
                        end
                        K_ONE, K_ONE_T:
                        begin
                            start_run = 1'b1;
                            run_src   = cmd[12:0];
                            run_len   = 8'd1;
                            run_tr    = (ckind == K_ONE_T);
                        end
                        K_CNT, K_CNT_T:
                        begin
                            psrc_next  = cmd[12:0];
                            ptr_next   = (ckind == K_CNT_T);
                            stage_next = PS_COUNT;
                        end
                        default:
                        begin
                            start_err = 1'b1;
                        end
                    endcase
                end
                PS_COUNT:
                begin
                    stage_next = PS_LOW;
                    if (stream_byte != '0)
                    begin
                        start_run = 1'b1;
                        run_src   = psrc_reg;
                        run_len   = stream_byte;
                        run_tr    = ptr_reg;
                    end
                end
                default:
                begin
                    start_run  = 1'b1;
                    run_src    = {5'd0, stream_byte};
                    run_len    = 8'd1;
                    extra_next = extra_dec;
                    if (extra_dec == '0)
                    begin
                        stage_next = PS_LOW;
                    end
                end
            endcase
            if (start_run)
            begin
                bcnt_next = bcnt_reg + {8'd0, run_len};
            end
            // frame end drops any unfinished command
            if (frame_end)
            begin
                stage_next = PS_LOW;
                low_next   = '0;
                psrc_next  = '0;
                ptr_next   = 1'b0;
                extra_next = '0;
                bcnt_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= PS_LOW;
            low_reg   <= '0;
            psrc_reg  <= '0;
            ptr_reg   <= 1'b0;
            extra_reg <= '0;
            bcnt_reg  <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            low_reg   <= low_next;
            psrc_reg  <= psrc_next;
            ptr_reg   <= ptr_next;
            extra_reg <= extra_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next = ST_DIV;
                end
                else if (start_err)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // restoring divider step: one quotient bit per cycle
    assign div_shift  = {rem_reg, quo_reg[BCNT_W-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, den_reg};
    assign div_borrow = div_diff[BYTE_W+1];

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dst_reg <= bcnt_reg;
                quo_reg <= bcnt_reg;
                rem_reg <= '0;
                den_reg <= (bpl_reg == '0) ? 8'd1 : bpl_reg;
                cnt_reg <= CNT_W'(BCNT_W - 1);
                err_reg <= start_err;
                src_reg <= run_src;
                len_reg <= run_len;
                tr_reg  <= run_tr;
                if (start_err)
                begin
                    col_reg    <= '0;
                    rowpix_reg <= '0;
                    cb_reg     <= '0;
                end
            end
            ST_DIV:
            begin
                quo_reg <= {quo_reg[BCNT_W-2:0], !div_borrow};
                rem_reg <= div_borrow ? div_shift[BYTE_W-1:0] : div_diff[BYTE_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_MUL1:
            begin
                col_reg  <= COL_W'(rem_reg) * COL_W'(bw_reg);
                row_reg  <= ROW_W'(quo_reg) * ROW_W'(bh_reg);
                area_reg <= AREA_W'(bw_reg) * AREA_W'(bh_reg);
            end
            ST_MUL2:
            begin
                rowpix_reg <= PROD_W'(row_reg) * PROD_W'(STRIDE_C);
                cb_reg     <= CB_W'(src_reg) * CB_W'(area_reg);
            end
            default: ;
        endcase
    end

    // frame offset: column plus row times stride
    assign fsum = SUM_W'(col_reg) + SUM_W'(rowpix_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg  <= err_reg ? RK_UNDEF : RK_PLACE;
            first_reg <= dst_reg;
            osrc_reg  <= src_reg;
            olen_reg  <= len_reg;
            otr_reg   <= tr_reg;
            fofs_reg  <= fsum[FOFS_W-1:0];
            cbofs_reg <= {cb_reg[CBOFS_W-2:0], 1'b0};
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign first_block     = first_reg;
    assign source_block    = osrc_reg;
    assign run_length      = olen_reg;
    assign transparent     = otr_reg;
    assign frame_offset    = fofs_reg;
    assign codebook_offset = cbofs_reg;

    // divisor is never zero while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("divider started with zero divisor");

    // finished division reproduces the block index
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL1 |->
            (rem_reg < den_reg) &&
            (24'(quo_reg) * 24'(den_reg) + 24'(rem_reg) == 24'(dst_reg)))
        else $error("divider result inconsistent");

    // extra source bytes are only taken while some remain
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && stage_reg == PS_EXTRA |-> extra_reg != '0)
        else $error("extra source byte with empty count");

    // a result appears only from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish state");

endmodule

FILE: dv/tb_vq_block_pointer_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_vq_block_pointer_decoder_core
// Self-checking bench for the vector-pointer decoder. A queue of pointer bytes,
// built as whole frames of commands with some cut frames and noise, feeds a
// bursty driver. A local decoder predicts the run descriptors at each accept.
// A monitor with its own stall pattern compares every field in order. Block
// geometry is changed between phases through the register port.
// ----------------------------------------------------------------------------
module tb_vq_block_pointer_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vqbpd_pkg::*;

    // command code with no defined meaning
    localparam logic [2:0] K_UNDEF_CMD = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              e;
    } ptr_item_t;

    typedef struct packed {
        logic               kind;
        logic [BCNT_W-1:0]  first_block;
        logic [SRC_W-1:0]   source_block;
        logic [LEN_W-1:0]   run_length;
        logic               transparent;
        logic [FOFS_W-1:0]  frame_offset;
        logic [CBOFS_W-1:0] codebook_offset;
    } run_desc_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    // block inputs, known from time zero
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic              in_valid = 1'b0;
    logic [BYTE_W-1:0] stream_byte = '0;
    logic              frame_end = 1'b0;
    logic              out_stall = 1'b0;

    // block outputs
    logic [31:0]        prdata;
    logic               pready;
    logic               in_stall;
    logic               out_valid;
    logic               kind;
    logic [BCNT_W-1:0]  first_block;
    logic [SRC_W-1:0]   source_block;
    logic [LEN_W-1:0]   run_length;
    logic               transparent;
    logic [FOFS_W-1:0]  frame_offset;
    logic [CBOFS_W-1:0] codebook_offset;

    vq_block_pointer_decoder_core #(
        .LINE_PITCH(LINE_PITCH_DEF)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stream_byte(stream_byte),
        .frame_end(frame_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .first_block(first_block),
        .source_block(source_block),
        .run_length(run_length),
        .transparent(transparent),
        .frame_offset(frame_offset),
        .codebook_offset(codebook_offset)
    );

    // pending pointer bytes and predicted descriptors
    ptr_item_t ptr_q[$];
    run_desc_t desc_q[$];
    int        bytes_pushed = 0;
    int        bytes_sent = 0;
    int        err_cnt = 0;

    // local geometry copy
    logic [BPL_W-1:0]  cfg_bpl = BPL_RST;
    logic [BDIM_W-1:0] cfg_bw = BW_RST;
    logic [BDIM_W-1:0] cfg_bh = BH_RST;

    // local parser state
    logic [1:0]         ps_stage = PS_LOW;
    logic [BYTE_W-1:0]  ps_low = '0;
    logic [SRC_W-1:0]   ps_src = '0;
    logic               ps_tr = 1'b0;
    logic [EXTRA_W-1:0] ps_extra = '0;
    logic [BCNT_W-1:0]  blk_cnt = '0;

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= 100)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s mismatch got 0x%0h want 0x%0h", name, got, want));
    endtask

    // one placement at the current block counter
    task automatic place_run(input logic [SRC_W-1:0] src, input logic [LEN_W-1:0] len,
                             input logic tr);
        longint unsigned div;
        longint unsigned col;
        longint unsigned row;
        longint unsigned fo;
        longint unsigned cb;
        run_desc_t d;
        div = (cfg_bpl == 0) ? 1 : cfg_bpl;
        col = (blk_cnt % div) * cfg_bw;
        row = (blk_cnt / div) * cfg_bh;
        fo = col + row * LINE_PITCH_DEF;
        cb = 2 * src * cfg_bw * cfg_bh;
        d.kind = RK_PLACE;
        d.first_block = blk_cnt;
        d.source_block = src;
        d.run_length = len;
        d.transparent = tr;
        d.frame_offset = fo[FOFS_W-1:0];
        d.codebook_offset = cb[CBOFS_W-1:0];
        desc_q.push_back(d);
        blk_cnt = blk_cnt + {8'd0, len};
    endtask

    // decode one accepted pointer byte
    task automatic decode_ptr_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [15:0] cmd;
        logic [7:0]  pairs;
        run_desc_t   d;
        cmd = {b, ps_low};
        pairs = {2'b00, cmd[12:8], 1'b0} + 8'd2;
        case (ps_stage)
            PS_LOW:
            begin
                ps_low = b;
                ps_stage = PS_HIGH;
            end
            PS_HIGH:
            begin
                ps_stage = PS_LOW;
                case (cmd[15:13])
                    K_SKIP: blk_cnt = blk_cnt + {3'b000, cmd[12:0]};
                    K_RUN: place_run({5'd0, cmd[7:0]}, pairs, 1'b0);
                    K_LIST:
                    begin
                        place_run({5'd0, cmd[7:0]}, 8'd1, 1'b0);
                        ps_extra = pairs[EXTRA_W-1:0];
                        ps_stage = PS_EXTRA;
                    end
                    K_ONE, K_ONE_T: place_run(cmd[12:0], 8'd1, cmd[15:13] == K_ONE_T);
                    K_CNT, K_CNT_T:
                    begin
                        ps_src = cmd[12:0];
                        ps_tr = (cmd[15:13] == K_CNT_T);
                        ps_stage = PS_COUNT;
                    end
                    default:
                    begin
                        d = '0;
                        d.kind = RK_UNDEF;
                        d.first_block = blk_cnt;
                        desc_q.push_back(d);
                    end
                endcase
            end
            PS_COUNT:
            begin
                ps_stage = PS_LOW;
                if (b != 0)
                    place_run(ps_src, b, ps_tr);
            end
            default:
            begin
                place_run({5'd0, b}, 8'd1, 1'b0);
                if (ps_extra != 0)
                    ps_extra--;
                if (ps_extra == 0)
                    ps_stage = PS_LOW;
            end
        endcase
        // frame end drops any unfinished command
        if (last)
        begin
            ps_stage = PS_LOW;
            ps_low = '0;
            ps_src = '0;
            ps_tr = 1'b0;
            ps_extra = '0;
            blk_cnt = '0;
        end
    endtask

    // stimulus building
    task automatic push_ptr(input logic [BYTE_W-1:0] b, input logic e);
        ptr_item_t it;
        it.b = b;
        it.e = e;
        ptr_q.push_back(it);
        bytes_pushed++;
    endtask

    task automatic push_cmd(input logic [2:0] k, input logic [12:0] arg);
        push_ptr(arg[7:0], 1'b0);
        push_ptr({k, arg[12:8]}, 1'b0);
    endtask

    task automatic add_random_cmd();
        int          r;
        int          n;
        logic [12:0] arg;
        r = $urandom_range(0, 99);
        arg = 13'($urandom);
        if (r < 10)
            push_cmd(K_SKIP, arg);
        else if (r < 24)
            push_cmd(K_RUN, arg);
        else if (r < 38)
        begin
            // mostly short source lists
            if ($urandom_range(0, 4) != 0)
                arg[12:8] = 5'($urandom_range(0, 2));
            push_cmd(K_LIST, arg);
            n = 2 * (arg[12:8] + 1);
            repeat (n) push_ptr(8'($urandom), 1'b0);
        end
        else if (r < 52)
            push_cmd(K_ONE, arg);
        else if (r < 62)
            push_cmd(K_ONE_T, arg);
        else if (r < 88)
        begin
            push_cmd((r < 75) ? K_CNT : K_CNT_T, arg);
            push_ptr(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0);
        end
        else if (r < 93)
            push_cmd(K_UNDEF_CMD, arg);
        else
            repeat ($urandom_range(1, 3)) push_ptr(8'($urandom), 1'b0);
    endtask

    // whole frames, some of them cut short
    task automatic fill_frames(input int n);
        int        base;
        int        frame_base;
        int        flen;
        ptr_item_t it;
        base = ptr_q.size();
        while (ptr_q.size() - base < n)
        begin
            frame_base = ptr_q.size();
            flen = $urandom_range(6, 100);
            while (ptr_q.size() - frame_base < flen)
                add_random_cmd();
            case ($urandom_range(0, 9))
                0: push_ptr(8'($urandom), 1'b1);
                1:
                begin
                    push_ptr(8'($urandom), 1'b0);
                    push_ptr({K_CNT_T, 5'($urandom)}, 1'b1);
                end
                2:
                begin
                    push_cmd(K_LIST, 13'($urandom));
                    push_ptr(8'($urandom), 1'b1);
                end
                default:
                begin
                    it = ptr_q.pop_back();
                    it.e = 1'b1;
                    ptr_q.push_back(it);
                end
            endcase
        end
    endtask

    // register write, setup then access
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BPL: cfg_bpl = val[BPL_W-1:0];
            REG_BW: cfg_bw = val[BDIM_W-1:0];
            default: cfg_bh = val[BDIM_W-1:0];
        endcase
    endtask

    // wait until the block has nothing left in flight
    task automatic drain();
        while (bytes_sent != bytes_pushed) @(posedge clk);
        while (desc_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // driver: bursts with random gaps
    ptr_item_t drv_item;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_ptr_byte(stream_byte, frame_end);
                bytes_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (ptr_q.size() != 0)
                begin
                    drv_item = ptr_q.pop_front();
                    in_valid <= 1'b1;
                    stream_byte <= drv_item.b;
                    frame_end <= drv_item.e;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    run_desc_t got_d;
    run_desc_t want_d;
    int        results_seen = 0;
    int        hold_left = 0;
    int        hold_idx = 0;
    int        stall_mode = 0;
    int        mode_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (desc_q.size() == 0)
                    report($sformatf("unexpected transaction first_block=0x%0h", first_block));
                else
                begin
                    want_d = desc_q.pop_front();
                    check_field("kind", kind, want_d.kind);
                    check_field("first_block", first_block, want_d.first_block);
                    check_field("source_block", source_block, want_d.source_block);
                    check_field("run_length", run_length, want_d.run_length);
                    check_field("transparent", transparent, want_d.transparent);
                    check_field("frame_offset", frame_offset, want_d.frame_offset);
                    check_field("codebook_offset", codebook_offset, want_d.codebook_offset);
                end
            end
            // two long hold-offs so the block backs up into its input
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_idx < 2 && results_seen >= ((hold_idx == 0) ? 120 : 520))
            begin
                out_stall <= 1'b1;
                hold_left = 1500;
                hold_idx++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 400);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // geometry settings per phase
    logic [BPL_W-1:0]  ph_bpl[5] = '{8'd1, 8'd255, 8'd0, 8'd160, 8'd37};
    logic [BDIM_W-1:0] ph_bw[5] = '{4'd1, 4'd8, 4'd8, 4'd4, 4'd3};
    logic [BDIM_W-1:0] ph_bh[5] = '{4'd1, 4'd8, 4'd1, 4'd2, 4'd7};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed frame at reset geometry
        push_cmd(K_SKIP, 13'h0000);
        push_cmd(K_RUN, 13'h1fff);
        push_cmd(K_RUN, 13'h0000);
        push_cmd(K_LIST, 13'h0000);
        push_ptr(8'h00, 1'b0);
        push_ptr(8'hff, 1'b0);
        push_cmd(K_ONE, 13'h1fff);
        push_cmd(K_ONE_T, 13'h0000);
        // count of zero places nothing
        push_cmd(K_CNT, 13'h0123);
        push_ptr(8'h00, 1'b0);
        push_cmd(K_CNT_T, 13'h1fff);
        push_ptr(8'hff, 1'b0);
        push_cmd(K_UNDEF_CMD, 13'h1fff);
        // frame end on a lone low byte
        push_ptr(8'h55, 1'b1);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            if (p < 5)
            begin
                reg_write(REG_BPL, {24'd0, ph_bpl[p]});
                reg_write(REG_BW, {28'd0, ph_bw[p]});
                reg_write(REG_BH, {28'd0, ph_bh[p]});
            end
            else
            begin
                reg_write(REG_BPL, $urandom_range(1, 255));
                reg_write(REG_BW, $urandom_range(1, 8));
                reg_write(REG_BH, $urandom_range(1, 8));
            end
            fill_frames(215);
            drain();
        end

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
